// ===== sv/rcsm_pkg.sv =====
// Types, constants and helper functions shared by the RC switch mode decoder.
package rcsm_pkg;

   // Field widths
   localparam int unsigned RAW_W  = 12;   // raw pulse width
   localparam int unsigned GAIN_W = 15;   // gain register
   localparam int unsigned VEL_W  = 16;   // signed velocity field
   localparam int unsigned CSR_IDX_W = 2;

   // Scaling datapath widths: |offset| * gain, then division by 419 via reciprocal
   localparam int unsigned PROD_W      = RAW_W + GAIN_W;   // 27 bits
   localparam int unsigned RECIP_W     = 28;
   localparam int unsigned RECIP_SHIFT = 36;
   localparam int unsigned FULL_W      = PROD_W + RECIP_W;
   localparam int unsigned QUOT_W      = 18;               // max quotient below 2^18
   // ceil(2^36 / 419): exact floor division for every product below 2^27
   localparam logic [RECIP_W-1:0] RECIP = 28'd164008298;

   // Snap targets
   localparam logic [RAW_W-1:0] SNAP_LOW  = 12'd1095;
   localparam logic [RAW_W-1:0] SNAP_MID  = 12'd1514;
   localparam logic [RAW_W-1:0] SNAP_HIGH = 12'd1933;

   // Window edges (closed windows; switch A/D use them as open windows)
   localparam logic [RAW_W-1:0] LOW_LO  = 12'd1075;
   localparam logic [RAW_W-1:0] LOW_HI  = 12'd1115;
   localparam logic [RAW_W-1:0] MID_LO  = 12'd1494;
   localparam logic [RAW_W-1:0] MID_HI  = 12'd1534;
   localparam logic [RAW_W-1:0] HIGH_LO = 12'd1913;
   localparam logic [RAW_W-1:0] HIGH_HI = 12'd1953;

   // Saturation limits
   localparam logic [QUOT_W-1:0] POS_LIMIT = 18'd32767;
   localparam logic [QUOT_W-1:0] NEG_LIMIT = 18'd32768;
   localparam logic signed [VEL_W-1:0] VEL_MAX = 16'sh7FFF;
   localparam logic signed [VEL_W-1:0] VEL_MIN = 16'sh8000;

   // Register indexes and reset values
   localparam logic [CSR_IDX_W-1:0] CSR_LINEAR_GAIN     = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ANGULAR_GAIN    = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_BODY_ANGLE_GAIN = 2'd2;
   localparam logic [GAIN_W-1:0] LINEAR_GAIN_RST     = 15'd1000;
   localparam logic [GAIN_W-1:0] ANGULAR_GAIN_RST    = 15'd1000;
   localparam logic [GAIN_W-1:0] BODY_ANGLE_GAIN_RST = 15'd18000;

   typedef enum logic [1:0] {
      SRC_REMOTE  = 2'd0,
      SRC_BUS     = 2'd1,
      SRC_STANDBY = 2'd2
   } source_type;

   typedef enum logic [2:0] {
      KIND_PARK     = 3'd0,
      KIND_NEUTRAL  = 3'd1,
      KIND_DIAGONAL = 3'd2,
      KIND_SPIN     = 3'd3,
      KIND_SIDEWAYS = 3'd4,
      KIND_STRAIGHT = 3'd5,
      KIND_TURNING  = 3'd6
   } kind_type;

   // Decoded positions of the three mode switches
   typedef struct packed {
      logic a_lo;
      logic a_hi;
      logic d_lo;
      logic d_hi;
      logic c_lo;
      logic c_mid;
      logic c_hi;
   } switch_flags_type;

   // Three-position snap, inclusive windows, high window checked first
   function automatic logic [RAW_W-1:0] snap_three(input logic [RAW_W-1:0] v);
      logic [RAW_W-1:0] r;
      r = v;
      if (v >= HIGH_LO && v <= HIGH_HI) begin
         r = SNAP_HIGH;
      end else if (v >= LOW_LO && v <= LOW_HI) begin
         r = SNAP_LOW;
      end else if (v >= MID_LO && v <= MID_HI) begin
         r = SNAP_MID;
      end
      return r;
   endfunction

   // Two-position snap, exclusive windows
   function automatic logic [RAW_W-1:0] snap_two(input logic [RAW_W-1:0] v);
      logic [RAW_W-1:0] r;
      r = v;
      if (v > LOW_LO && v < LOW_HI) begin
         r = SNAP_LOW;
      end else if (v > HIGH_LO && v < HIGH_HI) begin
         r = SNAP_HIGH;
      end
      return r;
   endfunction

   // Apply sign and saturate a quotient magnitude to 16 bits
   function automatic logic signed [VEL_W-1:0] sat_vel(input logic [QUOT_W-1:0] q,
                                                      input logic neg);
      logic signed [VEL_W-1:0] r;
      if (!neg) begin
         r = (q > POS_LIMIT) ? VEL_MAX : VEL_W'(q);
      end else if (q >= NEG_LIMIT) begin
         r = VEL_MIN;
      end else begin
         r = VEL_W'(16'd0 - VEL_W'(q));
      end
      return r;
   endfunction

endpackage

// ===== sv/rcsm_ifs.sv =====
// Request and response channel interfaces of the RC switch mode decoder.
interface rcsm_req_if;
   logic                      valid;
   logic                      ready;
   logic [rcsm_pkg::RAW_W-1:0] mode_switch;
   logic [rcsm_pkg::RAW_W-1:0] switch_a;
   logic [rcsm_pkg::RAW_W-1:0] throttle_stick;
   logic [rcsm_pkg::RAW_W-1:0] switch_d;
   logic [rcsm_pkg::RAW_W-1:0] switch_c;
   logic [rcsm_pkg::RAW_W-1:0] steer_stick;
   logic                      link_lost;

   modport source (output valid, mode_switch, switch_a, throttle_stick, switch_d,
                   switch_c, steer_stick, link_lost, input ready);
   modport sink   (input valid, mode_switch, switch_a, throttle_stick, switch_d,
                   switch_c, steer_stick, link_lost, output ready);
endinterface

interface rcsm_rsp_if;
   logic                             valid;
   logic                             ready;
   logic [1:0]                       control_source;
   logic [2:0]                       motion_kind;
   logic                             ackermann_steer;
   logic                             brake_on;
   logic signed [rcsm_pkg::VEL_W-1:0] linear_speed;
   logic signed [rcsm_pkg::VEL_W-1:0] turn_rate;
   logic signed [rcsm_pkg::VEL_W-1:0] heading_angle;
   logic                             publish_enable;

   modport source (output valid, control_source, motion_kind, ackermann_steer, brake_on,
                   linear_speed, turn_rate, heading_angle, publish_enable, input ready);
   modport sink   (input valid, control_source, motion_kind, ackermann_steer, brake_on,
                   linear_speed, turn_rate, heading_angle, publish_enable, output ready);
endinterface

// ===== sv/rc_switch_mode_decoder_top.sv =====
// RC switch mode decoder: snaps RC pulse widths and turns them into a drive command.
//
// Usage: each transaction on req_ch carries one RC frame (six raw pulse widths and the
// link-lost flag). Each accepted frame yields exactly one transaction on rsp_ch with the
// control source, motion kind, steering model, brake, three saturated velocities and
// the publish flag. Gains are to be written through csr_we/csr_index/csr_wdata while
// idle; the block itself does not enforce this. Each frame passes through the input
// register, gain multiply, reciprocal multiply and output register.
// Throughput: one transaction per cycle while rsp_ch.ready is high; every stage is a
// single pass and the two multiplier stages are pipelined, so a frame can follow in every cycle.
// Held state (motion kind, ackermann, brake, last mode switch, takeover latch) is
// updated in the last stage, in frame order.
// Reset: synchronous; empties all stages, clears held state and loads the default gains.
// Stall: each stage loads when empty or when the stage after it moves on, so while a
// response waits on rsp_ch.ready the empty stages upstream keep taking frames; the
// pipeline stops only when all four stages are full.
module rc_switch_mode_decoder_top (
   input  logic                                 clock,
   input  logic                                 reset,
   rcsm_req_if.sink                             req_ch,
   rcsm_rsp_if.source                           rsp_ch,
   input  logic                                 csr_we,
   input  logic [rcsm_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [rcsm_pkg::GAIN_W-1:0]          csr_wdata
);

   localparam int unsigned RAW_W  = rcsm_pkg::RAW_W;
   localparam int unsigned GAIN_W = rcsm_pkg::GAIN_W;
   localparam int unsigned PROD_W = rcsm_pkg::PROD_W;
   localparam int unsigned FULL_W = rcsm_pkg::FULL_W;
   localparam int unsigned QUOT_W = rcsm_pkg::QUOT_W;
   localparam int unsigned VEL_W  = rcsm_pkg::VEL_W;

   // ---------------------------------------------------------------- gain registers
   logic [GAIN_W-1:0] linear_gain_ff, angular_gain_ff, body_gain_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         linear_gain_ff  <= rcsm_pkg::LINEAR_GAIN_RST;
         angular_gain_ff <= rcsm_pkg::ANGULAR_GAIN_RST;
         body_gain_ff    <= rcsm_pkg::BODY_ANGLE_GAIN_RST;
      end else if (csr_we) begin
         case (csr_index)
            rcsm_pkg::CSR_LINEAR_GAIN:     linear_gain_ff  <= csr_wdata;
            rcsm_pkg::CSR_ANGULAR_GAIN:    angular_gain_ff <= csr_wdata;
            rcsm_pkg::CSR_BODY_ANGLE_GAIN: body_gain_ff    <= csr_wdata;
            default: ;
         endcase
      end
   end

   // ---------------------------------------------------------------- stage control
   logic s1_valid_ff, s2_valid_ff, s3_valid_ff, rsp_valid_ff;
   logic rsp_free, s3_free, s2_free, s1_free;
   logic s3_adv, s2_adv, s1_adv, req_take;

   assign rsp_free = !rsp_valid_ff || rsp_ch.ready;
   assign s3_free  = !s3_valid_ff || rsp_free;
   assign s2_free  = !s2_valid_ff || s3_free;
   assign s1_free  = !s1_valid_ff || s2_free;
   assign s3_adv   = s3_valid_ff && rsp_free;
   assign s2_adv   = s2_valid_ff && s3_free;
   assign s1_adv   = s1_valid_ff && s2_free;
   assign req_take = req_ch.valid && s1_free;

   assign req_ch.ready = s1_free;
   assign rsp_ch.valid = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (s1_free)  s1_valid_ff  <= req_ch.valid;
         if (s2_free)  s2_valid_ff  <= s1_valid_ff;
         if (s3_free)  s3_valid_ff  <= s2_valid_ff;
         if (rsp_free) rsp_valid_ff <= s3_valid_ff;
      end
   end

   // ---------------------------------------------------------------- stage 1: input register
   logic [RAW_W-1:0] s1_mode_ff, s1_sa_ff, s1_throttle_ff, s1_sd_ff, s1_sc_ff, s1_steer_ff;
   logic             s1_lost_ff;

   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_mode_ff     <= req_ch.mode_switch;
         s1_sa_ff       <= req_ch.switch_a;
         s1_throttle_ff <= req_ch.throttle_stick;
         s1_sd_ff       <= req_ch.switch_d;
         s1_sc_ff       <= req_ch.switch_c;
         s1_steer_ff    <= req_ch.steer_stick;
         s1_lost_ff     <= req_ch.link_lost;
      end
   end

   // ---------------------------------------------------------------- stage 2: snap and gain multiply
   logic [RAW_W-1:0] mode_snap, sa_snap, sd_snap, sc_snap, th_snap, st_snap;
   logic [RAW_W-1:0] lin_off, str_off;
   logic             lin_neg, str_neg;
   rcsm_pkg::switch_flags_type flags_in;

   always_comb begin
      mode_snap = rcsm_pkg::snap_three(s1_mode_ff);
      sa_snap   = rcsm_pkg::snap_two(s1_sa_ff);
      sd_snap   = rcsm_pkg::snap_two(s1_sd_ff);
      sc_snap   = rcsm_pkg::snap_three(s1_sc_ff);
      th_snap   = rcsm_pkg::snap_three(s1_throttle_ff);
      st_snap   = rcsm_pkg::snap_three(s1_steer_ff);

      flags_in.a_lo  = (sa_snap == rcsm_pkg::SNAP_LOW);
      flags_in.a_hi  = (sa_snap == rcsm_pkg::SNAP_HIGH);
      flags_in.d_lo  = (sd_snap == rcsm_pkg::SNAP_LOW);
      flags_in.d_hi  = (sd_snap == rcsm_pkg::SNAP_HIGH);
      flags_in.c_lo  = (sc_snap == rcsm_pkg::SNAP_LOW);
      flags_in.c_mid = (sc_snap == rcsm_pkg::SNAP_MID);
      flags_in.c_hi  = (sc_snap == rcsm_pkg::SNAP_HIGH);

      // stick offset from center as sign and magnitude
      lin_neg = (th_snap < rcsm_pkg::SNAP_MID);
      lin_off = lin_neg ? (rcsm_pkg::SNAP_MID - th_snap) : (th_snap - rcsm_pkg::SNAP_MID);
      str_neg = (st_snap < rcsm_pkg::SNAP_MID);
      str_off = str_neg ? (rcsm_pkg::SNAP_MID - st_snap) : (st_snap - rcsm_pkg::SNAP_MID);
   end

   logic [RAW_W-1:0]           s2_mode_ff;
   rcsm_pkg::switch_flags_type s2_flags_ff;
   logic                       s2_lost_ff, s2_lin_neg_ff, s2_str_neg_ff;
   logic [PROD_W-1:0]          s2_lin_mag_ff, s2_ang_mag_ff, s2_body_mag_ff;

   always_ff @(posedge clock) begin
      if (s1_adv) begin
         s2_mode_ff     <= mode_snap;
         s2_flags_ff    <= flags_in;
         s2_lost_ff     <= s1_lost_ff;
         s2_lin_neg_ff  <= lin_neg;
         s2_str_neg_ff  <= str_neg;
         s2_lin_mag_ff  <= PROD_W'(lin_off) * PROD_W'(linear_gain_ff);
         s2_ang_mag_ff  <= PROD_W'(str_off) * PROD_W'(angular_gain_ff);
         s2_body_mag_ff <= PROD_W'(str_off) * PROD_W'(body_gain_ff);
      end
   end

   // ---------------------------------------------------------------- stage 3: divide by 419
   logic [FULL_W-1:0] lin_full, ang_full, body_full;

   assign lin_full  = FULL_W'(s2_lin_mag_ff)  * FULL_W'(rcsm_pkg::RECIP);
   assign ang_full  = FULL_W'(s2_ang_mag_ff)  * FULL_W'(rcsm_pkg::RECIP);
   assign body_full = FULL_W'(s2_body_mag_ff) * FULL_W'(rcsm_pkg::RECIP);

   logic [RAW_W-1:0]           s3_mode_ff;
   rcsm_pkg::switch_flags_type s3_flags_ff;
   logic                       s3_lost_ff, s3_lin_neg_ff, s3_str_neg_ff;
   logic [QUOT_W-1:0]          s3_lin_q_ff, s3_ang_q_ff, s3_body_q_ff;

   always_ff @(posedge clock) begin
      if (s2_adv) begin
         s3_mode_ff    <= s2_mode_ff;
         s3_flags_ff   <= s2_flags_ff;
         s3_lost_ff    <= s2_lost_ff;
         s3_lin_neg_ff <= s2_lin_neg_ff;
         s3_str_neg_ff <= s2_str_neg_ff;
         s3_lin_q_ff   <= lin_full[rcsm_pkg::RECIP_SHIFT +: QUOT_W];
         s3_ang_q_ff   <= ang_full[rcsm_pkg::RECIP_SHIFT +: QUOT_W];
         s3_body_q_ff  <= body_full[rcsm_pkg::RECIP_SHIFT +: QUOT_W];
      end
   end

   // ---------------------------------------------------------------- stage 4: mode decode and held state
   logic [RAW_W-1:0]       prev_mode_ff, prev_mode_in;
   logic                   takeover_ff, takeover_in;
   rcsm_pkg::kind_type     held_kind_ff, held_kind_in;
   logic                   held_ack_ff, held_ack_in;
   logic                   held_brake_ff, held_brake_in;

   logic signed [VEL_W-1:0] lin_sat, ang_sat, body_sat;
   logic signed [VEL_W-1:0] lin_out, ang_out, body_out;
   rcsm_pkg::source_type    source;
   logic                    remote, bus, combo_stop, zero_vel;
   rcsm_pkg::switch_flags_type f;

   always_comb begin
      f        = s3_flags_ff;
      lin_sat  = rcsm_pkg::sat_vel(s3_lin_q_ff, s3_lin_neg_ff);
      ang_sat  = rcsm_pkg::sat_vel(s3_ang_q_ff, s3_str_neg_ff);
      body_sat = rcsm_pkg::sat_vel(s3_body_q_ff, s3_str_neg_ff);

      remote = (s3_mode_ff == rcsm_pkg::SNAP_HIGH);
      bus    = (s3_mode_ff == rcsm_pkg::SNAP_LOW);
      if (remote) begin
         source = rcsm_pkg::SRC_REMOTE;
      end else if (bus) begin
         source = rcsm_pkg::SRC_BUS;
      end else begin
         source = rcsm_pkg::SRC_STANDBY;
      end

      // mode switch change latches publishing
      prev_mode_in = s3_mode_ff;
      takeover_in  = takeover_ff || (s3_mode_ff != prev_mode_ff);

      held_kind_in  = held_kind_ff;
      held_ack_in   = held_ack_ff;
      held_brake_in = held_brake_ff;
      if (bus) begin
         held_kind_in = rcsm_pkg::KIND_PARK;
      end
      if (remote) begin
         if (f.a_lo && f.d_hi) begin
            held_kind_in = rcsm_pkg::KIND_NEUTRAL;
         end else if (f.a_lo && f.d_lo) begin
            held_kind_in = rcsm_pkg::KIND_PARK;
         end else if (f.a_hi && f.d_lo) begin
            if (f.c_lo) begin
               held_kind_in = rcsm_pkg::KIND_DIAGONAL;
            end else if (f.c_mid) begin
               held_kind_in = rcsm_pkg::KIND_SPIN;
            end else if (f.c_hi) begin
               held_kind_in = rcsm_pkg::KIND_SIDEWAYS;
            end
         end else if (f.a_hi && f.d_hi && f.c_hi) begin
            held_kind_in = (ang_sat == '0) ? rcsm_pkg::KIND_STRAIGHT
                                           : rcsm_pkg::KIND_TURNING;
         end
         held_ack_in   = f.a_hi && f.d_hi && f.c_mid;
         held_brake_in = f.a_hi && f.d_hi && f.c_lo;
      end

      // velocities only in remote mode, outside neutral/park and with a live link
      combo_stop = f.a_lo && (f.d_hi || f.d_lo);
      zero_vel   = !remote || combo_stop || s3_lost_ff;
      lin_out    = zero_vel ? '0 : lin_sat;
      ang_out    = zero_vel ? '0 : ang_sat;
      body_out   = zero_vel ? '0 : body_sat;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_mode_ff  <= '0;
         takeover_ff   <= 1'b0;
         held_kind_ff  <= rcsm_pkg::KIND_PARK;
         held_ack_ff   <= 1'b0;
         held_brake_ff <= 1'b0;
      end else if (s3_adv) begin
         prev_mode_ff  <= prev_mode_in;
         takeover_ff   <= takeover_in;
         held_kind_ff  <= held_kind_in;
         held_ack_ff   <= held_ack_in;
         held_brake_ff <= held_brake_in;
      end
   end

   // ---------------------------------------------------------------- output register
   logic [1:0]              rsp_source_ff;
   logic [2:0]              rsp_kind_ff;
   logic                    rsp_ack_ff, rsp_brake_ff, rsp_publish_ff;
   logic signed [VEL_W-1:0] rsp_lin_ff, rsp_ang_ff, rsp_body_ff;

   always_ff @(posedge clock) begin
      if (s3_adv) begin
         rsp_source_ff  <= source;
         rsp_kind_ff    <= held_kind_in;
         rsp_ack_ff     <= held_ack_in;
         rsp_brake_ff   <= held_brake_in;
         rsp_lin_ff     <= lin_out;
         rsp_ang_ff     <= ang_out;
         rsp_body_ff    <= body_out;
         rsp_publish_ff <= takeover_in;
      end
   end

   assign rsp_ch.control_source  = rsp_source_ff;
   assign rsp_ch.motion_kind     = rsp_kind_ff;
   assign rsp_ch.ackermann_steer = rsp_ack_ff;
   assign rsp_ch.brake_on        = rsp_brake_ff;
   assign rsp_ch.linear_speed    = rsp_lin_ff;
   assign rsp_ch.turn_rate       = rsp_ang_ff;
   assign rsp_ch.heading_angle   = rsp_body_ff;
   assign rsp_ch.publish_enable  = rsp_publish_ff;

endmodule
